### design/rgb_wheel_led_frame_encoder_assert.svh
// Assertion macros shared by the frame encoder modules.
`ifndef RGB_WHEEL_LED_FRAME_ENCODER_ASSERT_SVH
`define RGB_WHEEL_LED_FRAME_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check on every clock edge outside reset.
`define RWLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check on every clock edge, reset included.
`define RWLE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RWLE_ASSERT(name, prop, msg)
`define RWLE_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

### design/rwle_pkg.sv
// Types, constants and the color wheel function of the LED frame encoder.
`timescale 1ns / 1ps
`default_nettype none

package rwle_pkg;

  // Wheel geometry
  localparam logic [9:0] WHEEL_SPAN   = 10'd767;
  localparam logic [9:0] RAMP_1_START = 10'd255;
  localparam logic [9:0] RAMP_2_START = 10'd510;
  localparam logic [9:0] WHEEL_HOLD   = 10'd765;

  // Frame layout: 24 color bits per zone, four bytes per word
  localparam int unsigned COLOR_W        = 24;
  localparam int unsigned WORD_W         = 32;
  localparam logic [2:0]  SUB_LAST       = 3'd5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE    = 2'd0,
    CFG_ZONE_SPACING = 2'd1,
    CFG_ONE_PATTERN  = 2'd2,
    CFG_ZERO_PATTERN = 2'd3
  } cfg_reg_e;

  localparam logic [7:0] STEP_SIZE_RST    = 8'd5;
  localparam logic [7:0] ZONE_SPACING_RST = 8'd64;
  localparam logic [7:0] ONE_PATTERN_RST  = 8'd252;
  localparam logic [7:0] ZERO_PATTERN_RST = 8'd192;

  typedef struct packed {
    logic [7:0] step_size;
    logic [7:0] zone_spacing;
    logic [7:0] one_pattern;
    logic [7:0] zero_pattern;
  } cfg_t;

  // Request codes
  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_FILL = 1'b1
  } req_e;

  // Classified command handed from front to back
  typedef struct packed {
    logic               fill;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UPDATE = 3'b010,
    ST_SEND   = 3'b100
  } back_state_e;

  // Map a wheel position below 765 onto red, green, blue ramps
  function automatic logic [COLOR_W-1:0] wheel_color(input logic [9:0] p);
    logic [9:0] r, g, b;
    r = '0;
    g = '0;
    b = '0;
    if (p < RAMP_1_START) begin
      r = p;
      b = RAMP_1_START - p;
    end else if (p < RAMP_2_START) begin
      r = RAMP_2_START - p;
      g = p - RAMP_1_START;
    end else begin
      g = WHEEL_HOLD - p;
      b = p - RAMP_2_START;
    end
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

endpackage

`default_nettype wire

### design/rgb_wheel_led_frame_encoder.sv
// Top level of the color wheel LED frame encoder.
// Sequence: the back end takes an item from the queue in its idle state; a tick item then updates
// one zone per cycle, and both kinds send six words per zone, one word per cycle while the output is
// not stalled. The back end takes no new item until its frame is sent; the input queue takes
// QUEUE_DEPTH items while the back end is busy.
// Reset: asynchronous active low; clears queue, wheel position, zone colors and configuration
// to their defaults. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module rgb_wheel_led_frame_encoder
  import rwle_pkg::*;
#(
  parameter int unsigned ZONE_COUNT  = 4,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  req_type_i,
  input  wire logic [7:0]            fill_red_i,
  input  wire logic [7:0]            fill_green_i,
  input  wire logic [7:0]            fill_blue_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [WORD_W-1:0]          spi_word_o,
  output logic                       frame_end_o
);

  cfg_t cfg_q;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size    <= STEP_SIZE_RST;
      cfg_q.zone_spacing <= ZONE_SPACING_RST;
      cfg_q.one_pattern  <= ONE_PATTERN_RST;
      cfg_q.zero_pattern <= ZERO_PATTERN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_STEP_SIZE:    cfg_q.step_size    <= cfg_data_i;
        CFG_ZONE_SPACING: cfg_q.zone_spacing <= cfg_data_i;
        CFG_ONE_PATTERN:  cfg_q.one_pattern  <= cfg_data_i;
        CFG_ZERO_PATTERN: cfg_q.zero_pattern <= cfg_data_i;
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  rwle_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .fill_red_i   (fill_red_i),
    .fill_green_i (fill_green_i),
    .fill_blue_i  (fill_blue_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  rwle_back #(
    .ZONE_COUNT (ZONE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .spi_word_o  (spi_word_o),
    .frame_end_o (frame_end_o)
  );

endmodule

`default_nettype wire

### design/rwle_front.sv
// Front end: accepts items, classifies them and queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_wheel_led_frame_encoder_assert.svh"

module rwle_front
  import rwle_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       req_type_i,
  input  wire logic [7:0] fill_red_i,
  input  wire logic [7:0] fill_green_i,
  input  wire logic [7:0] fill_blue_i,
  output logic            cmd_valid_o,
  output cmd_t            cmd_o,
  input  wire logic       cmd_pop_i
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          queue_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push;
  cmd_t          cmd_in;

  // Classify the item: a tick carries no color
  always_comb begin
    cmd_in.fill  = (req_e'(req_type_i) == REQ_FILL);
    cmd_in.color = cmd_in.fill ? {fill_red_i, fill_green_i, fill_blue_i} : '0;
  end

  assign in_stall_o  = (count_q == CW'(QUEUE_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the command
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

  `RWLE_ASSERT(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "command queue overfilled")
  `RWLE_ASSERT(a_pop_nonempty, cmd_pop_i |-> count_q != '0, "pop from empty command queue")
  `RWLE_ASSERT(a_head_stable, cmd_valid_o && !cmd_pop_i |=> $stable(cmd_o), "waiting command changed")

endmodule

`default_nettype wire

### design/rwle_back.sv
// Back end: updates zone colors and serializes the coded frame.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_wheel_led_frame_encoder_assert.svh"

module rwle_back
  import rwle_pkg::*;
#(
  parameter int unsigned ZONE_COUNT = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              cmd_valid_i,
  input  wire cmd_t              cmd_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [WORD_W-1:0]      spi_word_o,
  output logic                   frame_end_o
);

  localparam int unsigned ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;

  back_state_e        state_q, state_d;
  logic [9:0]         pos_q, pos_d;
  logic [9:0]         off_q, off_d;
  logic [ZW-1:0]      zone_q, zone_d;
  logic [2:0]         sub_q, sub_d;
  logic [COLOR_W-1:0] color_q [ZONE_COUNT];
  logic               out_valid_q, out_valid_d;
  logic [WORD_W-1:0]  word_q;
  logic               end_q;

  logic               load;
  logic               last_zone;
  logic               last_word;
  logic [9:0]         pos_sum, pos_new, off_sum, off_new;
  logic [10:0]        p_sum;
  logic [9:0]         p;
  logic [COLOR_W-1:0] send_color;
  logic [3:0]         nibble;
  logic [WORD_W-1:0]  word_new;

  assign load      = !out_valid_q || !out_stall_i;
  assign last_zone = (zone_q == ZW'(ZONE_COUNT - 1));
  assign last_word = last_zone && (sub_q == SUB_LAST);
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  // Advance wheel position and zone offset, each reduced by one subtract
  always_comb begin
    pos_sum = pos_q + 10'(cfg_i.step_size);
    pos_new = (pos_sum >= WHEEL_SPAN) ? pos_sum - WHEEL_SPAN : pos_sum;
    off_sum = off_q + 10'(cfg_i.zone_spacing);
    off_new = (off_sum >= WHEEL_SPAN) ? off_sum - WHEEL_SPAN : off_sum;
    p_sum   = {1'b0, pos_new} + {1'b0, off_q};
    p       = (p_sum >= {1'b0, WHEEL_SPAN}) ? 10'(p_sum - {1'b0, WHEEL_SPAN})
                                            : p_sum[9:0];
  end

  // Pick four color bits for the next word and code them
  always_comb begin
    send_color = color_q[zone_q];
    unique case (sub_q)
      3'd0:    nibble = send_color[23:20];
      3'd1:    nibble = send_color[19:16];
      3'd2:    nibble = send_color[15:12];
      3'd3:    nibble = send_color[11:8];
      3'd4:    nibble = send_color[7:4];
      default: nibble = send_color[3:0];
    endcase
    for (int i = 0; i < 4; i++) begin
      word_new[WORD_W-1-8*i -: 8] = nibble[3-i] ? cfg_i.one_pattern : cfg_i.zero_pattern;
    end
  end

  // Sequence control
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    off_d       = off_q;
    zone_d      = zone_q;
    sub_d       = sub_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          zone_d  = '0;
          sub_d   = '0;
          off_d   = '0;
          state_d = cmd_i.fill ? ST_SEND : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        pos_d = pos_new;
        off_d = off_new;
        if (last_zone) begin
          zone_d  = '0;
          state_d = ST_SEND;
        end else begin
          zone_d = zone_q + 1'b1;
        end
      end
      ST_SEND: begin
        if (load) begin
          out_valid_d = 1'b1;
          if (last_word) begin
            state_d = ST_IDLE;
          end else if (sub_q == SUB_LAST) begin
            sub_d  = '0;
            zone_d = zone_q + 1'b1;
          end else begin
            sub_d = sub_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      off_q       <= '0;
      zone_q      <= '0;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      off_q       <= off_d;
      zone_q      <= zone_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Zone colors: fill all, or update one zone per tick cycle; hold at the dead positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int z = 0; z < ZONE_COUNT; z++) begin
        color_q[z] <= '0;
      end
    end else if (cmd_pop_o && cmd_i.fill) begin
      for (int z = 0; z < ZONE_COUNT; z++) begin
        color_q[z] <= cmd_i.color;
      end
    end else if ((state_q == ST_UPDATE) && (p < WHEEL_HOLD)) begin
      color_q[zone_q] <= wheel_color(p);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SEND) && load) begin
      word_q <= word_new;
      end_q  <= last_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign spi_word_o  = word_q;
  assign frame_end_o = end_q;

  `RWLE_ASSERT(a_pos_range, pos_q < WHEEL_SPAN, "wheel position out of range")
  `RWLE_ASSERT(a_off_range, off_q < WHEEL_SPAN, "zone offset out of range")
  `RWLE_ASSERT(a_word_from_send, $rose(out_valid_q) |-> $past(state_q) == ST_SEND, "word loaded outside send")

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the LED frame encoder: directed and random items, scoreboard.
`timescale 1ns / 1ps

module tb_top
  import rwle_pkg::*;
();

  localparam int unsigned ZONES           = 4;
  localparam int unsigned WHEEL_MOD       = 767;
  localparam int unsigned WORDS_PER_FRAME = ZONES * 6;
  localparam int unsigned QUIET_LIMIT     = 3000;
  localparam int unsigned TAIL_CYCLES     = ZONES + 8;

  typedef struct {
    req_e       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_cmd_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } spi_beat_t;

  // DUT inputs, known from time zero
  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = CFG_STEP_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  req_type_i   = REQ_TICK;
  logic [7:0]            fill_red_i   = '0;
  logic [7:0]            fill_green_i = '0;
  logic [7:0]            fill_blue_i  = '0;
  logic                  out_stall_i  = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [WORD_W-1:0]     spi_word_o;
  logic                  frame_end_o;

  // Shadow of the block's registers and state
  cfg_t        cfg_shadow;
  int unsigned wheel_pos;
  logic [23:0] zone_rgb [ZONES];

  led_cmd_t  pending_cmds [$];
  spi_beat_t expected_beats [$];

  int unsigned fail_count     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_gap       = 0;
  int unsigned long_hold_left = 0;
  bit          sender_idle_en = 1'b1;
  bit          recv_idle_en   = 1'b1;

  rgb_wheel_led_frame_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .fill_red_i   (fill_red_i),
    .fill_green_i (fill_green_i),
    .fill_blue_i  (fill_blue_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .spi_word_o   (spi_word_o),
    .frame_end_o  (frame_end_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Map a wheel position onto the three ramps; the top two positions hold the old color
  function automatic logic [23:0] wheel_rgb(int unsigned p, logic [23:0] prev);
    logic [7:0] r, g, b;
    if (p < 255) begin
      r = 8'(p);
      g = 8'd0;
      b = 8'(255 - p);
    end else if (p < 510) begin
      r = 8'(510 - p);
      g = 8'(p - 255);
      b = 8'd0;
    end else if (p < 765) begin
      r = 8'd0;
      g = 8'(765 - p);
      b = 8'(p - 510);
    end else begin
      return prev;
    end
    return {r, g, b};
  endfunction

  // Update zone colors for one item and queue the coded words of its frame
  task automatic predict_frame(logic is_fill, logic [23:0] fill_rgb);
    int unsigned p;
    int unsigned nbytes;
    int unsigned nwords;
    logic [WORD_W-1:0] word;
    spi_beat_t beat;
    nbytes = 0;
    nwords = 0;
    word   = '0;
    for (int unsigned z = 0; z < ZONES; z++) begin
      if (is_fill) begin
        zone_rgb[z] = fill_rgb;
      end else begin
        wheel_pos   = (wheel_pos + cfg_shadow.step_size) % WHEEL_MOD;
        p           = (wheel_pos + (z * cfg_shadow.zone_spacing) % WHEEL_MOD) % WHEEL_MOD;
        zone_rgb[z] = wheel_rgb(p, zone_rgb[z]);
      end
    end
    for (int unsigned z = 0; z < ZONES; z++) begin
      for (int i = 23; i >= 0; i--) begin
        word = {word[23:0], zone_rgb[z][i] ? cfg_shadow.one_pattern : cfg_shadow.zero_pattern};
        nbytes++;
        if (nbytes == 4) begin
          nwords++;
          beat.word = word;
          beat.last = (nwords == WORDS_PER_FRAME);
          expected_beats.push_back(beat);
          nbytes = 0;
          word   = '0;
        end
      end
    end
  endtask

  // Sender: hold a stalled item, otherwise idle a burst or offer the next item
  always @(posedge clk_i) begin
    led_cmd_t cmd;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cmd = pending_cmds.pop_front();
        in_valid_i   <= 1'b1;
        req_type_i   <= cmd.kind;
        fill_red_i   <= cmd.red;
        fill_green_i <= cmd.green;
        fill_blue_i  <= cmd.blue;
        if (sender_idle_en && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(1, 19);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off on request, else random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      out_stall_i <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall_i <= 1'b1;
    end else if (recv_idle_en && $urandom_range(0, 15) == 0) begin
      recv_gap = $urandom_range(1, 19) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: check output words, predict accepted items, watch for a hang
  always @(posedge clk_i) begin
    spi_beat_t want;
    logic      word_taken;
    logic      item_taken;
    word_taken = rst_ni && out_valid_o && !out_stall_i;
    item_taken = rst_ni && in_valid_i && !in_stall_o;
    if (word_taken) begin
      if (expected_beats.size() == 0) begin
        $error("spi_word with no frame pending: actual %h", spi_word_o);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (spi_word_o !== want.word) begin
          $error("spi_word mismatch: expected %h, actual %h", want.word, spi_word_o);
          fail_count++;
        end
        if (frame_end_o !== want.last) begin
          $error("frame_end mismatch: expected %b, actual %b", want.last, frame_end_o);
          fail_count++;
        end
      end
    end
    if (item_taken) begin
      predict_frame(req_type_i == REQ_FILL, {fill_red_i, fill_green_i, fill_blue_i});
    end
    if (rst_ni) begin
      quiet_cycles = (word_taken || item_taken) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Write one register at the next edge and mirror it in the shadow
  task automatic write_reg(cfg_reg_e idx, logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_STEP_SIZE:    cfg_shadow.step_size    = value;
      CFG_ZONE_SPACING: cfg_shadow.zone_spacing = value;
      CFG_ONE_PATTERN:  cfg_shadow.one_pattern  = value;
      CFG_ZERO_PATTERN: cfg_shadow.zero_pattern = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_config(logic [7:0] step, logic [7:0] spacing,
                             logic [7:0] one_byte, logic [7:0] zero_byte);
    @(posedge clk_i);
    write_reg(CFG_STEP_SIZE, step);
    write_reg(CFG_ZONE_SPACING, spacing);
    write_reg(CFG_ONE_PATTERN, one_byte);
    write_reg(CFG_ZERO_PATTERN, zero_byte);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_cmd(req_e kind, logic [23:0] rgb);
    led_cmd_t cmd;
    cmd.kind  = kind;
    cmd.red   = rgb[23:16];
    cmd.green = rgb[15:8];
    cmd.blue  = rgb[7:0];
    pending_cmds.push_back(cmd);
  endtask

  // Wait until every item is taken and every word has come, then let the block settle
  task automatic drain();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_beats.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // Random byte, biased toward the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_random_cmd();
    queue_cmd($urandom_range(0, 1) ? REQ_FILL : REQ_TICK,
              {pick_byte(), pick_byte(), pick_byte()});
  endtask

  initial begin
    int unsigned n;
    cfg_shadow.step_size    = STEP_SIZE_RST;
    cfg_shadow.zone_spacing = ZONE_SPACING_RST;
    cfg_shadow.one_pattern  = ONE_PATTERN_RST;
    cfg_shadow.zero_pattern = ZERO_PATTERN_RST;
    wheel_pos = 0;
    foreach (zone_rgb[z]) zone_rgb[z] = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset configuration, fills only so the wheel stays at zero
    queue_cmd(REQ_FILL, 24'h5AA5C3);
    queue_cmd(REQ_FILL, 24'h000000);
    queue_cmd(REQ_FILL, 24'hFFFFFF);
    drain();

    // Zone two lands on position 766 and keeps its fill color
    load_config(8'd254, 8'd2, 8'hFF, 8'h00);
    queue_cmd(REQ_FILL, 24'hA55A3C);
    queue_cmd(REQ_TICK, 24'h000000);
    drain();

    // Zone three lands on position 765 and keeps its color
    load_config(8'd0, 8'd172, 8'h00, 8'hFF);
    queue_cmd(REQ_TICK, 24'hFFFFFF);
    queue_cmd(REQ_FILL, 24'h123456);
    drain();

    load_config(STEP_SIZE_RST, ZONE_SPACING_RST, ONE_PATTERN_RST, ZERO_PATTERN_RST);
    repeat (4) queue_cmd(REQ_TICK, 24'h000000);
    queue_cmd(REQ_FILL, 24'h800001);
    queue_cmd(REQ_FILL, 24'h7FFFFE);
    drain();

    // Largest step and spacing
    load_config(8'd255, 8'd255, 8'hAA, 8'h55);
    repeat (3) queue_cmd(REQ_TICK, 24'h000000);
    queue_cmd(REQ_FILL, 24'h0F0F0F);
    drain();

    // Random phases, each with its own configuration and idling mix
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0:       load_config(8'd255, 8'd255, 8'hFF, 8'h00);
        1:       load_config(8'd0, 8'd0, 8'h00, 8'hFF);
        default: load_config(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      endcase
      sender_idle_en = (phase % 3 != 2) && (phase != 4);
      recv_idle_en   = (phase % 4 != 1);
      // Hold the receiver off while the sender keeps offering, so the input backs up
      if (phase == 4) long_hold_left = 300;
      n = $urandom_range(10, 22);
      repeat (n) queue_random_cmd();
      drain();
    end

    // Closing stretch at full rate on both sides
    sender_idle_en = 1'b0;
    recv_idle_en   = 1'b0;
    load_config(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    repeat (16) queue_random_cmd();
    drain();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
